### src/pctd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared widths and constants for the trial-division prime counter.
// ----------------------------------------------------------------------------
package pctd_pkg;

    // Default width of the tested value
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of the running prime count
    localparam int TALLY_W = 32;

    // Result tdata: is_prime in bit 0, prime_total above, padded to bytes
    localparam int OUT_W = ((TALLY_W + 1 + 7) / 8) * 8;

    // Saturation value of the count
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // First odd trial divisor and its square
    localparam int FIRST_DIV = 3;
    localparam int FIRST_DIV_SQ = FIRST_DIV * FIRST_DIV;

endpackage : pctd_pkg
`default_nettype wire

### src/prime_counter_trial_division.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_counter_trial_division
// Trial-division primality test with a saturating running prime count.
// ----------------------------------------------------------------------------
// Sequence: negative, small and even values, and 2, pass from the accepting
//   state straight to the finish state; an odd value n alternates a test of
//   d * d > n with a restoring division of n by each odd divisor d from 3,
//   forming each remainder one bit a cycle, and stops at the first d that divides
//   n or, for a prime, once d * d exceeds n (about sqrt(n) / 2 divisors tried).
// Throughput: one item at a time; the next item is taken once the result has
//   moved into the output register, which holds it until taken.
// Reset: synchronous, active low; clears the count, the control state and the
//   output valid.
module prime_counter_trial_division
    import pctd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input item
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
    input  wire logic              s_tlast,   // last_item
    // result item
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // [0] is_prime, [32:1] prime_total
);

    localparam int W     = VALUE_WIDTH;
    localparam int D_W   = W / 2 + 2;
    localparam int SQ_W  = W + 2;
    localparam int CNT_W = $clog2(W);
    localparam int PAD_W = OUT_W - TALLY_W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [W-1:0]        n_reg;
    logic [W-1:0]        n_sh_reg;
    logic [D_W-1:0]      d_reg;
    logic [SQ_W-1:0]     dsq_reg;
    logic [D_W-1:0]      rem_reg;
    logic [CNT_W-1:0]    bit_cnt_reg;
    logic                prime_reg;
    logic                last_reg;
    logic [TALLY_W-1:0]  tally_reg;
    logic                m_tvalid_reg;
    logic                out_prime_reg;
    logic [TALLY_W-1:0]  out_total_reg;

    // Input decode
    logic [W-1:0] in_value;
    logic         in_trivial;
    logic         in_trivial_prime;

    assign in_value = s_tdata[W-1:0];

    always_comb begin
        in_trivial       = 1'b1;
        in_trivial_prime = 1'b0;
        priority if (in_value[W-1]) begin
            in_trivial = 1'b1;
        end else if (in_value[W-1:1] == '0) begin
            in_trivial = 1'b1;
        end else if (in_value == W'(2)) begin
            in_trivial_prime = 1'b1;
        end else if (!in_value[0]) begin
            in_trivial = 1'b1;
        end else begin
            in_trivial = 1'b0;
        end
    end

    // One restoring division step: shift in the next dividend bit
    logic [D_W:0]   rem_shift;
    logic [D_W:0]   rem_sub;
    logic [D_W-1:0] rem_step;

    assign rem_shift = {rem_reg, n_sh_reg[W-1]};
    assign rem_sub   = rem_shift - {1'b0, d_reg};
    assign rem_step  = (rem_shift >= {1'b0, d_reg}) ? rem_sub[D_W-1:0]
                                                     : rem_shift[D_W-1:0];

    // Next odd divisor square: (d + 2)^2 = d^2 + 4d + 4
    logic [SQ_W-1:0] dsq_step;
    logic            sq_over;

    assign dsq_step = dsq_reg + {{(SQ_W - D_W - 2){1'b0}}, d_reg, 2'b00} + SQ_W'(4);
    assign sq_over  = dsq_reg > {2'b00, n_reg};

    // Count update when a result is loaded
    logic               out_free;
    logic [TALLY_W-1:0] tally_inc;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign tally_inc = (prime_reg && (tally_reg != TALLY_MAX)) ? tally_reg + TALLY_W'(1)
                                                               : tally_reg;

    // Control, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tally_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Set valid on a load, clear it once the result is taken
            if ((state_reg == ST_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        n_reg     <= in_value;
                        last_reg  <= s_tlast;
                        prime_reg <= in_trivial_prime;
                        d_reg     <= D_W'(FIRST_DIV);
                        dsq_reg   <= SQ_W'(FIRST_DIV_SQ);
                        state_reg <= in_trivial ? ST_FINISH : ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (sq_over) begin
                        // no divisor up to the square root: prime
                        prime_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        rem_reg     <= '0;
                        n_sh_reg    <= n_reg;
                        bit_cnt_reg <= CNT_W'(W - 1);
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg     <= rem_step;
                    n_sh_reg    <= {n_sh_reg[W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
                    if (bit_cnt_reg == '0) begin
                        if (rem_step == '0) begin
                            // divisor found: composite
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end else begin
                            d_reg     <= d_reg + D_W'(2);
                            dsq_reg   <= dsq_step;
                            state_reg <= ST_TEST;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        out_prime_reg <= prime_reg;
                        out_total_reg <= tally_inc;
                        tally_reg     <= last_reg ? '0 : tally_inc;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_total_reg, out_prime_reg};

endmodule : prime_counter_trial_division
`default_nettype wire

### src/pctd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_checker
// Port-level checks for the trial-division prime counter, bound to the top.
// ----------------------------------------------------------------------------
module pctd_checker
    import pctd_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A prime result always carries a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[TALLY_W:1] != '0))
        else $error("prime result with zero count");

    // Drop ready in the cycle after an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after accepted item");

    // No result right after reset
    assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule : pctd_checker

bind prime_counter_trial_division pctd_checker u_pctd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/prime_count_checker.sv
// ----------------------------------------------------------------------------
// prime_count_checker
// Watches both channels of the trial-division prime counter. Each accepted
// input item is classified here as prime or not, the stream's prime count is
// advanced (saturating, cleared after a last item), and the outcome is queued.
// Each accepted result item is compared with the oldest queued outcome.
// ----------------------------------------------------------------------------
module prime_count_checker
    import pctd_pkg::*;
#(
    parameter int VAL_W = VALUE_WIDTH_DEF,
    localparam int DATA_W = ((VAL_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [VAL_W-1:0] value
    input  wire logic              s_tlast,   // last_item
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [OUT_W-1:0]  m_tdata,   // [0] is_prime, [32:1] prime_total
    output int unsigned            fail_count,
    output int unsigned            pending
);

    typedef struct packed {
        logic               is_prime;
        logic [TALLY_W-1:0] prime_total;
    } prime_outcome_t;

    prime_outcome_t       queued_outcomes[$];
    logic [TALLY_W-1:0]   stream_primes;

    // Trial division with odd divisors while d * d <= n, written as d <= n / d
    function automatic logic value_is_prime(input logic [VAL_W-1:0] v);
        longint unsigned n;
        longint unsigned d;
        n = longint'(v);
        if (v[VAL_W-1]) return 1'b0;
        if (n <= 1) return 1'b0;
        if (n == 2) return 1'b1;
        if (n % 2 == 0) return 1'b0;
        for (d = FIRST_DIV; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        prime_outcome_t seen;
        prime_outcome_t want;
        int unsigned    errs;
        errs = 0;
        if (!aresetn) begin
            queued_outcomes.delete();
            stream_primes = '0;
            fail_count <= 0;
            pending <= 0;
        end else begin
            // Compare a result item against the oldest outcome
            if (m_tvalid && m_tready) begin
                seen.is_prime = m_tdata[0];
                seen.prime_total = m_tdata[TALLY_W:1];
                if (queued_outcomes.size() == 0) begin
                    $error("result item with no outcome waiting: is_prime %0d prime_total %0d",
                           seen.is_prime, seen.prime_total);
                    errs++;
                end else begin
                    want = queued_outcomes.pop_front();
                    if (seen.is_prime !== want.is_prime) begin
                        $error("is_prime: expected %0d, actual %0d",
                               want.is_prime, seen.is_prime);
                        errs++;
                    end
                    if (seen.prime_total !== want.prime_total) begin
                        $error("prime_total: expected %0d, actual %0d",
                               want.prime_total, seen.prime_total);
                        errs++;
                    end
                end
            end
            // Classify an input item and advance the stream count
            if (s_tvalid && s_tready) begin
                want.is_prime = value_is_prime(s_tdata[VAL_W-1:0]);
                if (want.is_prime && stream_primes != TALLY_MAX)
                    stream_primes = stream_primes + 1'b1;
                want.prime_total = stream_primes;
                queued_outcomes.push_back(want);
                if (s_tlast)
                    stream_primes = '0;
            end
            fail_count <= fail_count + errs;
            pending <= queued_outcomes.size();
        end
    end

endmodule : prime_count_checker

### tb/sv/prime_counter_trial_division_tb.sv
// ----------------------------------------------------------------------------
// prime_counter_trial_division_tb
// Drives integers into the prime counter, first a directed set (sign and range
// extremes, small values, even values, squares, last-item clearing), then
// random values kept mostly small or quick to reject so the run stays short.
// Both channels idle at random; the checker module does the comparisons.
// ----------------------------------------------------------------------------
module prime_counter_trial_division_tb;
    import pctd_pkg::*;

    localparam int VAL_W = VALUE_WIDTH_DEF;
    localparam int DATA_W = ((VAL_W + 7) / 8) * 8;
    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 80;
    localparam logic [VAL_W-1:0] VALUE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VALUE_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;    // [VAL_W-1:0] value
    logic              s_tlast = 1'b0;  // last_item
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // [0] is_prime, [32:1] prime_total

    int unsigned fail_count;
    int unsigned pending;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          steady = 1'b0;

    prime_counter_trial_division #(.VALUE_WIDTH(VAL_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    prime_count_checker #(.VAL_W(VAL_W)) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keep odd candidates small or built with a small factor, so trial
    // division ends quickly; negatives and large even values toggle high bits
    function automatic logic [VAL_W-1:0] random_value();
        int unsigned      pick;
        int unsigned      p;
        int unsigned      hi;
        logic [VAL_W-1:0] v;
        pick = $urandom_range(0, 99);
        v = $urandom();
        if (pick < 35) return $urandom_range(0, 2000);
        if (pick < 50) return $urandom_range(0, 65535);
        if (pick < 65) begin
            v[VAL_W-1] = 1'b1;
            return v;
        end
        if (pick < 80) begin
            v[VAL_W-1] = 1'b0;
            v[0] = 1'b0;
            return v;
        end
        p = 2 * $urandom_range(1, 30) + 1;
        hi = VALUE_MAX / p;
        return p * (2 * $urandom_range(0, (hi - 1) / 2) + 1);
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [VAL_W-1:0] value, input bit last);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= DATA_W'(value);
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Result-side backpressure: random stalls, none in steady phases
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 1) == 1)
                stall_left <= pick_gap();
        end
    end

    // End the run if no item moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sign and range extremes, small values, evens, odd squares
        send_item(VALUE_MIN, 1'b0);
        send_item({VAL_W{1'b1}}, 1'b0);
        send_item(0, 1'b0);
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(3, 1'b0);
        send_item(4, 1'b0);
        send_item(9, 1'b0);
        send_item(25, 1'b0);
        // Prime on the last item: count includes it, then clears
        send_item(97, 1'b1);
        send_item(5, 1'b0);
        send_item(121, 1'b0);
        send_item(65521, 1'b0);
        send_item(65535, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MAX - 1, 1'b0);
        send_item(1000003, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        // Back-to-back last items
        send_item(7, 1'b1);
        send_item(11, 1'b1);
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 40 && i < 60);
            send_item(random_value(), $urandom_range(0, 9) == 0);
            if (i == 70)
                wait_for_results();
        end
        steady = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule : prime_counter_trial_division_tb

### files.f
src/pctd_pkg.sv
src/prime_counter_trial_division.sv
src/pctd_checker.sv
tb/sv/prime_count_checker.sv
tb/sv/prime_counter_trial_division_tb.sv
